[design/mcwdt_pkg.sv]
// Package with the types, sizes and request codes of the multi-client watchdog table.
package mcwdt_pkg;

  localparam int unsigned SLOTS    = 4096;
  localparam int unsigned SLOT_AW  = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned ID_W     = 12;
  localparam int unsigned OWNER_W  = 16;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned TIME_W   = 48;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_KICK     = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_TICK     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [ID_W-1:0]     slot_id;
    logic [OWNER_W-1:0]  owner_tag;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] granted_slot;
    logic            expired;
    logic [ID_W-1:0] expired_slot;
  } rsp_t;

  typedef struct packed {
    logic                active;
    logic [OWNER_W-1:0]  owner;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   deadline;
  } slot_t;

endpackage

[design/multi_client_watchdog_table_top.sv]
// Top level of the multi-client watchdog table: slot memory, free stack and sequencer.
//
// Usage: requests enter on in_valid_i / in_stall_o / in_req_i and each one gives exactly
// one response on out_valid_o / out_stall_i / out_rsp_o. A transfer happens at a rising
// edge where valid is high and stall is low. Requests are handled one at a time; the
// block takes a new request whenever its sequencer is idle, even while the previous
// response still waits in the output register.
// A register request goes straight to the done state when a fresh slot is available and
// through the pop state when it pops the free stack. Kick and release pass through the
// check state, since they read the slot entry from the slot memory before writing it back.
// A tick reads one slot per cycle from the slot memory, starting at slot 0, and stops at
// the first slot whose deadline has passed or at the last slot ever handed out. It
// goes straight to the done state without a read while no slot was ever handed out;
// the single read port of the slot memory sets the pace of the scan.
// Reset clears the time, the counters, the shutdown flag and the output valid flag. The
// memories are not cleared: slots at or above the fresh pointer count as inactive.
// When the receiver stalls, the response is held unchanged in the output register and a
// finished request waits in its last state until the output register is free again.
module multi_client_watchdog_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mcwdt_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mcwdt_pkg::rsp_t out_rsp_o
);
  import mcwdt_pkg::*;

  // Sequencer and architectural state.
  state_e             state_q, state_d;
  req_t               req_q, req_d;
  rsp_t               res_q, res_d;
  rsp_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [CNT_W-1:0]   next_fresh_q, next_fresh_d;
  logic [CNT_W-1:0]   free_count_q, free_count_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic               tripped_q, tripped_d;
  logic [SLOT_AW-1:0] scan_idx_q, scan_idx_d;

  // Slot memory: one entry per slot, with a registered read port.
  slot_t              slot_mem [SLOTS];
  slot_t              slot_rd_q;
  logic               slot_re;
  logic [SLOT_AW-1:0] slot_raddr;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  slot_t              slot_wdata;

  // Free stack memory holding released slot numbers.
  logic [SLOT_AW-1:0] fs_mem [SLOTS];
  logic [SLOT_AW-1:0] fs_rd_q;
  logic               fs_re;
  logic [SLOT_AW-1:0] fs_raddr;
  logic               fs_we;
  logic [SLOT_AW-1:0] fs_waddr;
  logic [SLOT_AW-1:0] fs_wdata;

  // Shared conditions.
  logic               in_accept;
  logic               out_free;
  logic               fresh_ok;
  logic               id_in_range;
  logic               owner_ok;
  logic               scan_hit;
  logic               scan_last;
  logic [CNT_W-1:0]   free_top;
  logic [CNT_W-1:0]   fresh_last;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign fresh_ok    = (next_fresh_q < SLOTS_CNT);
  assign free_top    = free_count_q - CNT_W'(1);
  assign fresh_last  = next_fresh_q - CNT_W'(1);

  // A slot is only valid once handed out, which also rejects ids beyond the table.
  assign id_in_range = ({1'b0, req_q.slot_id} < (ID_W + 1)'(next_fresh_q));
  assign owner_ok    = id_in_range && slot_rd_q.active && (slot_rd_q.owner == req_q.owner_tag);

  // During a scan, slot_rd_q holds the entry of slot scan_idx_q.
  assign scan_hit    = slot_rd_q.active && (slot_rd_q.deadline <= now_q);
  assign scan_last   = (CNT_W'(scan_idx_q) == fresh_last);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_req_i.op)
            OP_REGISTER: begin
              if (fresh_ok) begin
                state_d = S_DONE;
              end else if (free_count_q != '0) begin
                state_d = S_POP;
              end else begin
                state_d = S_DONE;
              end
            end
            OP_KICK, OP_RELEASE: begin
              state_d = S_CHECK;
            end
            OP_TICK: begin
              state_d = (next_fresh_q == '0) ? S_DONE : S_SCAN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_POP:   state_d = S_DONE;
      S_CHECK: state_d = S_DONE;
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory controls and response.
  always_comb begin
    req_d        = req_q;
    res_d        = res_q;
    next_fresh_d = next_fresh_q;
    free_count_d = free_count_q;
    now_d        = now_q;
    tripped_d    = tripped_q;
    scan_idx_d   = scan_idx_q;
    slot_re      = 1'b0;
    slot_raddr   = '0;
    slot_we      = 1'b0;
    slot_waddr   = '0;
    slot_wdata   = slot_rd_q;
    fs_re        = 1'b0;
    fs_raddr     = '0;
    fs_we        = 1'b0;
    fs_waddr     = '0;
    fs_wdata     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d              = in_req_i;
          res_d.ok           = 1'b0;
          res_d.granted_slot = '0;
          res_d.expired      = tripped_q;
          res_d.expired_slot = '0;
          case (in_req_i.op)
            OP_REGISTER: begin
              if (fresh_ok) begin
                // A fresh slot needs no read: its entry is written outright.
                slot_we             = 1'b1;
                slot_waddr          = next_fresh_q[SLOT_AW-1:0];
                slot_wdata.active   = 1'b1;
                slot_wdata.owner    = in_req_i.owner_tag;
                slot_wdata.period   = in_req_i.period;
                slot_wdata.deadline = now_q + TIME_W'(in_req_i.period);
                next_fresh_d        = next_fresh_q + CNT_W'(1);
                res_d.ok            = 1'b1;
                res_d.granted_slot  = ID_W'(next_fresh_q);
              end else if (free_count_q != '0) begin
                fs_re    = 1'b1;
                fs_raddr = free_top[SLOT_AW-1:0];
              end
            end
            OP_KICK, OP_RELEASE: begin
              slot_re    = 1'b1;
              slot_raddr = in_req_i.slot_id[SLOT_AW-1:0];
            end
            OP_TICK: begin
              now_d    = now_q + TIME_W'(1);
              res_d.ok = 1'b1;
              if (next_fresh_q != '0) begin
                slot_re    = 1'b1;
                slot_raddr = '0;
                scan_idx_d = '0;
              end
            end
            default: begin
              res_d.ok = 1'b0;
            end
          endcase
        end
      end
      S_POP: begin
        slot_we             = 1'b1;
        slot_waddr          = fs_rd_q;
        slot_wdata.active   = 1'b1;
        slot_wdata.owner    = req_q.owner_tag;
        slot_wdata.period   = req_q.period;
        slot_wdata.deadline = now_q + TIME_W'(req_q.period);
        free_count_d        = free_top;
        res_d.ok            = 1'b1;
        res_d.granted_slot  = ID_W'(fs_rd_q);
      end
      S_CHECK: begin
        if (owner_ok) begin
          if (req_q.op == OP_KICK) begin
            slot_we             = 1'b1;
            slot_waddr          = req_q.slot_id[SLOT_AW-1:0];
            slot_wdata.deadline = now_q + TIME_W'(slot_rd_q.period);
            res_d.ok            = 1'b1;
          end else if (free_count_q < SLOTS_CNT) begin
            slot_we           = 1'b1;
            slot_waddr        = req_q.slot_id[SLOT_AW-1:0];
            slot_wdata.active = 1'b0;
            fs_we             = 1'b1;
            fs_waddr          = free_count_q[SLOT_AW-1:0];
            fs_wdata          = req_q.slot_id[SLOT_AW-1:0];
            free_count_d      = free_count_q + CNT_W'(1);
            res_d.ok          = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          tripped_d          = 1'b1;
          res_d.expired      = 1'b1;
          res_d.expired_slot = ID_W'(scan_idx_q);
        end else if (!scan_last) begin
          slot_re    = 1'b1;
          slot_raddr = scan_idx_q + SLOT_AW'(1);
          scan_idx_d = scan_idx_q + SLOT_AW'(1);
        end
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // Output register: loads a finished response once the previous one has gone.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if ((state_q == S_DONE) && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      next_fresh_q <= '0;
      free_count_q <= '0;
      now_q        <= '0;
      tripped_q    <= 1'b0;
      scan_idx_q   <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      next_fresh_q <= next_fresh_d;
      free_count_q <= free_count_d;
      now_q        <= now_d;
      tripped_q    <= tripped_d;
      scan_idx_q   <= scan_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_rd_q <= fs_mem[fs_raddr];
    end
  end

endmodule
